>>> rtl/adba_pkg.sv
// ----------------------------------------------------------------------------
// adba_pkg
// shared widths, register indexes and reset values of the depth block averager
// ----------------------------------------------------------------------------
package adba_pkg;

    localparam int MAX_AVERAGE_DEF = 64;
    localparam int CODE_BITS_DEF   = 12;

    localparam int CH_W    = 4;
    localparam int SPA_W   = 7;
    localparam int OFF_W   = 13;
    localparam int LIM_W   = 5;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam int DEPTH_W = 18;
    localparam int USED_W  = 7;
    localparam int ACC_W   = 24;
    localparam int MV_W    = 13;
    localparam int RAW_W   = 20;
    localparam int IT_W    = $clog2(ACC_W + 1);

    localparam logic [MV_W-1:0]    VREF_MV     = 13'd5000;
    localparam logic [6:0]         DEPTH_SCALE = 7'd125;
    localparam logic [1:0]         DEPTH_DIV   = 2'd3;
    localparam logic [DEPTH_W-1:0] ZERO_DEPTH  = 18'd13500;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_AVERAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET_MM     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LIMIT       = 2'd2;

    localparam logic [SPA_W-1:0] SPA_RESET = 7'd50;
    localparam logic [OFF_W-1:0] OFF_RESET = 13'd3380;
    localparam logic [LIM_W-1:0] LIM_RESET = 5'd10;

endpackage

>>> rtl/adba_sample_if.sv
// ----------------------------------------------------------------------------
// adba_sample_if
// sample channel: adc sample or flush request with valid/ready handshake
// ----------------------------------------------------------------------------
interface adba_sample_if
    import adba_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [CH_W-1:0]      channel;
    logic [CODE_BITS-1:0] code;

    modport source (output valid, output kind, output channel, output code, input ready);
    modport sink   (input valid, input kind, input channel, input code, output ready);
endinterface

>>> rtl/adba_result_if.sv
// ----------------------------------------------------------------------------
// adba_result_if
// result channel: averaged depth with valid/ready handshake
// ----------------------------------------------------------------------------
interface adba_result_if
    import adba_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] avg_depth;
    logic [USED_W-1:0]  samples_used;
    logic               partial;

    modport source (output valid, output avg_depth, output samples_used, output partial,
                    input ready);
    modport sink   (input valid, input avg_depth, input samples_used, input partial,
                    output ready);
endinterface

>>> rtl/adc_depth_block_averager_top.sv
// ----------------------------------------------------------------------------
// adc_depth_block_averager_top
// Converts adc codes to depth in 1/16 mm and averages them in blocks.
//
// sample_ch carries one adc sample (kind 0) or a flush request (kind 1) per
// transaction; result_ch carries one averaged depth per transaction. The
// configuration port writes a register when cfg_wr_en is high.
// A kept sample runs the multiply states ST_MUL1 and ST_MUL2, a CODE-to-depth
// division by three through the bit-serial divider (ST_DIV3) and an accumulate
// step (ST_ACCUM), after which the block is ready unless the sample completes
// a block. That sample, or a flush with samples held, goes on to a bit-serial
// sum/count division (ST_DIVAVG) and a load of the result register (ST_EMIT)
// before the block is ready again. Dropped samples and empty flushes leave the
// block idle and ready.
// Reset clears the sum and count and loads the default register values.
// A stalled receiver holds the result in the output register; the block keeps
// taking samples until it has a further result to place there.
// ----------------------------------------------------------------------------
module adc_depth_block_averager_top
    import adba_pkg::*;
#(
    parameter int MAX_AVERAGE = MAX_AVERAGE_DEF,
    parameter int CODE_BITS   = CODE_BITS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    adba_sample_if.sink          sample_ch,
    adba_result_if.source        result_ch
);

    localparam int CNT_W  = $clog2(MAX_AVERAGE + 1);
    localparam int DIV_W  = (CNT_W > 2) ? CNT_W : 2;
    localparam int PROD_W = CODE_BITS + MV_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV3,
        ST_ACCUM,
        ST_DIVAVG,
        ST_EMIT
    } state_t;

    state_t               state_reg;
    logic [SPA_W-1:0]     spa_reg;
    logic [OFF_W-1:0]     off_reg;
    logic [LIM_W-1:0]     lim_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic [MV_W-1:0]      mv_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     divisor_reg;
    logic [IT_W-1:0]      it_reg;
    logic                 partial_reg;
    logic                 res_valid_reg;
    logic [DEPTH_W-1:0]   res_avg_reg;
    logic [USED_W-1:0]    res_used_reg;
    logic                 res_partial_reg;

    logic [DIV_W:0]       trial;
    logic                 trial_ge;
    logic [DIV_W-1:0]     rem_next;
    logic [ACC_W-1:0]     quo_next;
    logic [PROD_W-1:0]    prod;
    logic [RAW_W-1:0]     raw;
    logic [DEPTH_W-1:0]   sub;
    logic [DEPTH_W-1:0]   depth_q;
    logic [DEPTH_W-1:0]   depth;
    logic [ACC_W:0]       sum_wide;
    logic [ACC_W-1:0]     acc_next;
    logic [CNT_W-1:0]     cnt_next;
    logic [CNT_W-1:0]     target;
    logic                 keep;
    logic                 accept;
    logic                 res_load;

    // one restoring division step
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ACC_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
        rem_next = trial_ge ? DIV_W'(trial - {1'b0, divisor_reg}) : trial[DIV_W-1:0];
        quo_next = {quo_reg[ACC_W-2:0], trial_ge};
    end

    always_comb
    begin
        prod     = PROD_W'(code_reg) * PROD_W'(VREF_MV);
        raw      = RAW_W'(mv_reg) * RAW_W'(DEPTH_SCALE);
        sub      = ZERO_DEPTH + DEPTH_W'({off_reg, 4'b0000});
        depth_q  = quo_reg[DEPTH_W-1:0];
        depth    = (depth_q >= sub) ? depth_q - sub : '0;
        sum_wide = {1'b0, acc_reg} + (ACC_W + 1)'(depth);
        acc_next = sum_wide[ACC_W] ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
        cnt_next = cnt_reg + CNT_W'(1);
        if (spa_reg == '0)
        begin
            target = CNT_W'(1);
        end
        else if (int'(spa_reg) > MAX_AVERAGE)
        begin
            target = CNT_W'(MAX_AVERAGE);
        end
        else
        begin
            target = CNT_W'(spa_reg);
        end
        keep     = {1'b0, sample_ch.channel} < lim_reg;
        accept   = sample_ch.valid && sample_ch.ready;
        res_load = (state_reg == ST_EMIT) && (!res_valid_reg || result_ch.ready);
    end

    assign sample_ch.ready        = (state_reg == ST_IDLE);
    assign result_ch.valid        = res_valid_reg;
    assign result_ch.avg_depth    = res_avg_reg;
    assign result_ch.samples_used = res_used_reg;
    assign result_ch.partial      = res_partial_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spa_reg <= SPA_RESET;
            off_reg <= OFF_RESET;
            lim_reg <= LIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SAMPLES_PER_AVERAGE: spa_reg <= cfg_data[SPA_W-1:0];
                REG_DEPTH_OFFSET_MM:     off_reg <= cfg_data[OFF_W-1:0];
                REG_CHANNEL_LIMIT:       lim_reg <= cfg_data[LIM_W-1:0];
                default:                 ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            code_reg        <= '0;
            mv_reg          <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            divisor_reg     <= '0;
            it_reg          <= '0;
            partial_reg     <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_avg_reg     <= '0;
            res_used_reg    <= '0;
            res_partial_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && result_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (sample_ch.kind)
                        begin
                            if (cnt_reg != '0)
                            begin
                                quo_reg     <= acc_reg;
                                rem_reg     <= '0;
                                divisor_reg <= DIV_W'(cnt_reg);
                                it_reg      <= IT_W'(ACC_W);
                                partial_reg <= 1'b1;
                                state_reg   <= ST_DIVAVG;
                            end
                        end
                        else if (keep)
                        begin
                            code_reg  <= sample_ch.code;
                            state_reg <= ST_MUL1;
                        end
                    end
                end
                ST_MUL1:
                begin
                    mv_reg    <= MV_W'(prod >> CODE_BITS);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    quo_reg     <= {raw, {(ACC_W - RAW_W){1'b0}}};
                    rem_reg     <= '0;
                    divisor_reg <= DIV_W'(DEPTH_DIV);
                    it_reg      <= IT_W'(RAW_W);
                    state_reg   <= ST_DIV3;
                end
                ST_DIV3:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    it_reg  <= it_reg - IT_W'(1);
                    if (it_reg == IT_W'(1))
                    begin
                        state_reg <= ST_ACCUM;
                    end
                end
                ST_ACCUM:
                begin
                    acc_reg <= acc_next;
                    cnt_reg <= cnt_next;
                    if (cnt_next >= target)
                    begin
                        quo_reg     <= acc_next;
                        rem_reg     <= '0;
                        divisor_reg <= DIV_W'(cnt_next);
                        it_reg      <= IT_W'(ACC_W);
                        partial_reg <= 1'b0;
                        state_reg   <= ST_DIVAVG;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIVAVG:
                begin
                    quo_reg <= quo_next;
                    rem_reg <= rem_next;
                    it_reg  <= it_reg - IT_W'(1);
                    if (it_reg == IT_W'(1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    // wait for the output register to be free
                    if (res_load)
                    begin
                        res_avg_reg     <= quo_reg[DEPTH_W-1:0];
                        res_used_reg    <= USED_W'(cnt_reg);
                        res_partial_reg <= partial_reg;
                        acc_reg         <= '0;
                        cnt_reg         <= '0;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // count never passes the block size limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= MAX_AVERAGE)
        else $error("sample count above limit");

    // an empty block holds no sum
    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> acc_reg == '0)
        else $error("sum held with no samples");

    // loading a result clears the block
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!res_valid_reg || result_ch.ready))
        |=> (res_valid_reg && cnt_reg == '0 && acc_reg == '0 && state_reg == ST_IDLE))
        else $error("result load did not clear the block");

endmodule

>>> tb/adba_tb_pkg.sv
// ----------------------------------------------------------------------------
// adba_tb_pkg
// item kinds shared by the stimulus and the checker of the depth block averager
// ----------------------------------------------------------------------------
package adba_tb_pkg;

    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_FLUSH  = 1'b1
    } item_kind_t;

endpackage

>>> tb/depth_average_checker.sv
// ----------------------------------------------------------------------------
// depth_average_checker
// Watches the sample, result and register ports of the depth block averager.
// Each accepted sample below the channel limit updates a local copy of the
// running depth sum and count; a finished block or a non-empty flush queues
// the expected average, checked field by field with the next accepted result.
// ----------------------------------------------------------------------------
module depth_average_checker
    import adba_pkg::*;
    import adba_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    adba_sample_if               sample_ch,
    adba_result_if               result_ch,
    output int                   errors,
    output int                   pending,
    output int                   results_checked,
    output int                   partials_checked
);

    localparam logic [ACC_W:0] ACC_SAT = {1'b0, {ACC_W{1'b1}}};

    typedef struct packed
    {
        logic [DEPTH_W-1:0] avg_depth;
        logic [USED_W-1:0]  samples_used;
        logic               partial;
    } depth_result_t;

    logic [SPA_W-1:0]  block_len_cfg = SPA_RESET;
    logic [OFF_W-1:0]  offset_cfg    = OFF_RESET;
    logic [LIM_W-1:0]  ch_limit_cfg  = LIM_RESET;
    logic [ACC_W-1:0]  blk_sum       = '0;
    logic [USED_W-1:0] depth_count   = '0;
    depth_result_t     avg_expect_q[$];

    function automatic logic [DEPTH_W-1:0] depth_of_code(input logic [CODE_BITS_DEF-1:0] code,
                                                         input logic [OFF_W-1:0] offset);
        logic [31:0] mv;
        logic [31:0] raw;
        int          depth;
        mv    = (32'(code) * 32'(VREF_MV)) >> CODE_BITS_DEF;
        raw   = (mv * 32'(DEPTH_SCALE)) / 32'(DEPTH_DIV);
        depth = int'(raw) - int'(ZERO_DEPTH) - 16 * int'(offset);
        if (depth < 0)
        begin
            depth = 0;
        end
        return depth[DEPTH_W-1:0];
    endfunction

    task automatic absorb_item(input item_kind_t kind, input logic [CH_W-1:0] ch,
                               input logic [CODE_BITS_DEF-1:0] code);
        logic [ACC_W:0]    sum;
        logic [USED_W-1:0] goal;
        logic              close;
        logic              is_partial;
        depth_result_t     res;
        close      = 1'b0;
        is_partial = 1'b0;
        if (kind == KIND_FLUSH)
        begin
            close      = (depth_count != 0);
            is_partial = 1'b1;
        end
        else if (ch < ch_limit_cfg)
        begin
            goal = block_len_cfg;
            if (block_len_cfg == 0)
            begin
                goal = USED_W'(1);
            end
            else if (block_len_cfg > MAX_AVERAGE_DEF)
            begin
                goal = USED_W'(MAX_AVERAGE_DEF);
            end
            sum         = blk_sum + depth_of_code(code, offset_cfg);
            blk_sum     = (sum > ACC_SAT) ? ACC_SAT[ACC_W-1:0] : sum[ACC_W-1:0];
            depth_count = depth_count + 1'b1;
            close       = (depth_count >= goal);
        end
        if (close)
        begin
            res.avg_depth    = DEPTH_W'(blk_sum / depth_count);
            res.samples_used = depth_count;
            res.partial      = is_partial;
            avg_expect_q.push_back(res);
            blk_sum     = '0;
            depth_count = '0;
        end
    endtask

    task automatic report(input string what, input int exp_val, input int act_val);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_len_cfg = SPA_RESET;
            offset_cfg    = OFF_RESET;
            ch_limit_cfg  = LIM_RESET;
            blk_sum       = '0;
            depth_count   = '0;
            avg_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SAMPLES_PER_AVERAGE: block_len_cfg = cfg_data[SPA_W-1:0];
                    REG_DEPTH_OFFSET_MM:     offset_cfg    = cfg_data[OFF_W-1:0];
                    REG_CHANNEL_LIMIT:       ch_limit_cfg  = cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (avg_expect_q.size() == 0)
                begin
                    report("unexpected result transaction, avg_depth", -1,
                           result_ch.avg_depth);
                end
                else
                begin
                    depth_result_t exp_res;
                    exp_res = avg_expect_q.pop_front();
                    if (exp_res.avg_depth != result_ch.avg_depth)
                    begin
                        report("avg_depth", exp_res.avg_depth, result_ch.avg_depth);
                    end
                    if (exp_res.samples_used != result_ch.samples_used)
                    begin
                        report("samples_used", exp_res.samples_used, result_ch.samples_used);
                    end
                    if (exp_res.partial != result_ch.partial)
                    begin
                        report("partial", exp_res.partial, result_ch.partial);
                    end
                    results_checked++;
                    if (exp_res.partial)
                    begin
                        partials_checked++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                absorb_item(item_kind_t'(sample_ch.kind), sample_ch.channel, sample_ch.code);
            end
            pending <= avg_expect_q.size();
        end
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the depth block averager with directed cases for reset values,
// channel limits, count settings and flushes, then with random sample
// transactions under several settings and sender/receiver idling patterns,
// including a long receiver hold-off and a mid-run drain. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import adba_pkg::*;
    import adba_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 225;
    localparam int RANDOM_PHASES   = 8;
    localparam int QUIET_CYCLES    = 60;
    localparam int HOLD_CYCLES     = 600;
    localparam int STALL_LIMIT     = 4000;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic [LIM_W-1:0]     lim_now = LIM_RESET;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_req      = 0;
    int hold_done     = 0;
    int quiet_run     = 0;
    int items_sent    = 0;
    int chk_errors;
    int chk_pending;
    int chk_results;
    int chk_partials;

    adba_sample_if sample_ch ();
    adba_result_if result_ch ();

    adc_depth_block_averager_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    depth_average_checker i_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_ch        (sample_ch),
        .result_ch        (result_ch),
        .errors           (chk_errors),
        .pending          (chk_pending),
        .results_checked  (chk_results),
        .partials_checked (chk_partials)
    );

    always #2 clk = ~clk;

    // receiver side, long hold-off counted here
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                hold_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            quiet_run <= 0;
        end
        else
        begin
            quiet_run <= quiet_run + 1;
            if (quiet_run >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_item(input item_kind_t kind, input logic [CH_W-1:0] ch,
                             input logic [CODE_BITS_DEF-1:0] code);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.kind    <= kind;
        sample_ch.channel <= ch;
        sample_ch.code    <= code;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // block may still be busy on a sample that yields no result
    task automatic settle();
        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input int spa, input int off, input int lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SAMPLES_PER_AVERAGE;
        cfg_data  <= CFG_W'(($urandom_range(0, 63) << SPA_W) | spa);
        @(posedge clk);
        cfg_index <= REG_DEPTH_OFFSET_MM;
        cfg_data  <= CFG_W'(off);
        @(posedge clk);
        cfg_index <= REG_CHANNEL_LIMIT;
        cfg_data  <= CFG_W'(($urandom_range(0, 255) << LIM_W) | lim);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lim_now = LIM_W'(lim);
    endtask

    task automatic run_phase(input int p);
        int                         spa;
        int                         off;
        int                         lim;
        int                         counted;
        int                         ch_top;
        bit                         drained;
        item_kind_t                 kind;
        logic [CH_W-1:0]            ch;
        logic [CODE_BITS_DEF-1:0]   code;
        settle();
        spa = $urandom_range(1, 6);
        off = $urandom_range(0, 8191);
        lim = $urandom_range(1, 31);
        case (p)
            0: spa = 1;
            1:
            begin
                spa = 64;
                off = 0;
            end
            2:
            begin
                spa = 0;
                lim = 16;
            end
            3:
            begin
                spa = 127;
                off = 8191;
            end
            4:
            begin
                spa = 1;
                lim = 1;
            end
            5: lim = 31;
            default: ;
        endcase
        load_settings(spa, off, lim);
        case (p % 4)
            0:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            1:
            begin
                src_idle_pct  = 80;
                snk_stall_pct = 0;
            end
            2:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 80;
            end
            default:
            begin
                src_idle_pct  = 34;
                snk_stall_pct = 34;
            end
        endcase
        // output register fills and the sample input backs up
        if (p == 4)
        begin
            hold_req++;
        end
        counted = 0;
        drained = 1'b0;
        while (counted < ITEMS_PER_PHASE)
        begin
            if (p == 6 && !drained && counted >= ITEMS_PER_PHASE / 2)
            begin
                drained = 1'b1;
                drain_results();
            end
            kind   = ($urandom_range(0, 99) < 4) ? KIND_FLUSH : KIND_SAMPLE;
            ch_top = (lim_now > 16) ? 16 : int'(lim_now);
            if (ch_top > 0 && $urandom_range(0, 99) < 85)
            begin
                ch = CH_W'($urandom_range(0, ch_top - 1));
            end
            else
            begin
                ch = CH_W'($urandom_range(0, 15));
            end
            case ($urandom_range(0, 11))
                0: code = '0;
                1: code = '1;
                default: code = CODE_BITS_DEF'($urandom);
            endcase
            send_item(kind, ch, code);
            counted++;
        end
    endtask

    initial
    begin
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_SAMPLES_PER_AVERAGE;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.kind    = KIND_SAMPLE;
        sample_ch.channel = '0;
        sample_ch.code    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        send_item(KIND_SAMPLE, 4'd9, 12'd3000);
        send_item(KIND_SAMPLE, 4'd10, 12'd3000);
        send_item(KIND_FLUSH, 4'd0, 12'd0);
        settle();

        // code extremes, empty flush, flush with data
        load_settings(2, 0, 16);
        send_item(KIND_SAMPLE, 4'd0, 12'd0);
        send_item(KIND_SAMPLE, 4'd15, 12'd4095);
        send_item(KIND_FLUSH, 4'd7, 12'hABC);
        send_item(KIND_SAMPLE, 4'd9, 12'd2048);
        send_item(KIND_FLUSH, 4'd15, 12'd4095);
        settle();

        // zero channel limit drops all
        load_settings(0, 8191, 0);
        send_item(KIND_SAMPLE, 4'd0, 12'd4095);
        send_item(KIND_FLUSH, 4'd0, 12'd0);
        settle();

        // zero count acts as one, largest offset clamps
        load_settings(0, 8191, 31);
        send_item(KIND_SAMPLE, 4'd3, 12'd0);
        send_item(KIND_SAMPLE, 4'd15, 12'd4095);
        settle();

        // count above maximum, limit of one
        load_settings(127, 3380, 1);
        send_item(KIND_SAMPLE, 4'd1, 12'd4095);
        send_item(KIND_SAMPLE, 4'd0, 12'd1000);
        send_item(KIND_SAMPLE, 4'd0, 12'd2500);
        send_item(KIND_SAMPLE, 4'd0, 12'd4095);
        send_item(KIND_FLUSH, 4'd0, 12'd0);
        settle();

        // count lowered while a block is half full
        load_settings(10, 100, 16);
        for (int i = 0; i < 5; i++)
        begin
            send_item(KIND_SAMPLE, CH_W'(i), CODE_BITS_DEF'($urandom));
        end
        settle();
        load_settings(3, 100, 16);
        send_item(KIND_SAMPLE, 4'd5, 12'd3500);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            run_phase(p);
        end
        settle();

        $display("covered %0d sample/flush transactions: directed cases and %0d random phases",
                 items_sent, RANDOM_PHASES);
        $display("checked %0d averaged results, %0d of them partial", chk_results, chk_partials);
        if (chk_errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/adba_pkg.sv
rtl/adba_sample_if.sv
rtl/adba_result_if.sv
rtl/adc_depth_block_averager_top.sv
tb/adba_tb_pkg.sv
tb/depth_average_checker.sv
tb/testbench.sv
